@@ sv/bitmap_page_allocator_defines.svh @@
// Assertion macros used by the assertion checker of the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bitmap page allocator check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bitmap page allocator check failed");

`endif

@@ sv/bpa_pkg.sv @@
// Types and constants shared by the bitmap page allocator modules.
`default_nettype none

package bpa_pkg;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam logic [7:0] BYTE_FULL = 8'hFF;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_MARK    = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_ALLOC,
        ST_MODIFY,
        ST_RESP
    } state_t;

    typedef enum logic [2:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_HINT,
        ADDR_PAGE,
        ADDR_INC
    } addr_op_t;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_GRANT,
        WR_SET,
        WR_CLEAR
    } wr_kind_t;

    typedef enum logic [1:0] {
        HINT_HOLD,
        HINT_SET,
        HINT_LOWER
    } hint_op_t;

    typedef enum logic [1:0] {
        RES_DONE,
        RES_GRANT,
        RES_FAIL
    } res_kind_t;

    typedef struct packed {
        logic      req_load;
        addr_op_t  addr_op;
        logic      rd_ahead;
        logic      ram_we;
        wr_kind_t  wr_kind;
        hint_op_t  hint_op;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       page_ok;
        logic       addr_last;
        logic       free_found;
        logic       out_free;
    } ctrl_stat_t;

endpackage

`default_nettype wire

@@ sv/bpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/bpa_datapath.sv @@
// Datapath of the page allocator: request registers, bitmap memory, hint and result.
`default_nettype none

module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = 65536
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ctrl_cmd_t              cmd,
    output ctrl_stat_t                  stat,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    localparam int MAP_BYTES = (NUM_PAGES + 7) / 8;
    localparam int AW = $clog2(MAP_BYTES);
    localparam int LAST_BITS = NUM_PAGES % 8;
    localparam logic [7:0] LAST_MASK = (LAST_BITS == 0) ? BYTE_FULL :
                                       8'((1 << LAST_BITS) - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);
    localparam logic [31:0] NUM_PAGES_W = 32'(NUM_PAGES);

    logic [1:0]    op_reg;
    logic [15:0]   page_reg;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] hint_reg, hint_next;
    logic [15:0]   res_page_reg;
    logic          res_status_reg;
    logic [15:0]   out_page_reg;
    logic          out_status_reg;
    logic          out_vld_reg, out_vld_next;

    logic [31:0]   page_byte_w;
    logic [AW-1:0] page_addr;
    logic [AW-1:0] addr_ahead;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    ram_wdata;
    logic [7:0]    free_bits;
    logic [2:0]    found_bit;
    logic [7:0]    page_mask;
    logic [7:0]    grant_mask;
    logic [31:0]   grant_w;
    logic          addr_last;

    assign page_byte_w = {19'b0, page_reg[15:3]};
    assign page_addr   = page_byte_w[AW-1:0];
    assign addr_last   = (addr_reg == LAST_ADDR);
    assign addr_ahead  = addr_last ? addr_reg : addr_reg + AW'(1);
    assign ram_raddr   = cmd.rd_ahead ? addr_ahead : addr_reg;
    assign free_bits   = ~ram_rdata & (addr_last ? LAST_MASK : BYTE_FULL);
    assign page_mask   = 8'b1 << page_reg[2:0];
    assign grant_mask  = 8'b1 << found_bit;
    assign grant_w     = {{(29 - AW){1'b0}}, addr_reg, found_bit};

    always_comb begin
        found_bit = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (free_bits[i]) begin
                found_bit = 3'(i);
            end
        end
    end

    always_comb begin
        case (cmd.wr_kind)
            WR_ZERO:  ram_wdata = 8'h00;
            WR_GRANT: ram_wdata = ram_rdata | grant_mask;
            WR_SET:   ram_wdata = ram_rdata | page_mask;
            WR_CLEAR: ram_wdata = ram_rdata & ~page_mask;
            default:  ram_wdata = 8'h00;
        endcase
    end

    bpa_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_bitmap (
        .clk   (aclk),
        .we    (cmd.ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        case (cmd.addr_op)
            ADDR_HOLD: addr_next = addr_reg;
            ADDR_ZERO: addr_next = '0;
            ADDR_HINT: addr_next = hint_reg;
            ADDR_PAGE: addr_next = page_addr;
            ADDR_INC:  addr_next = addr_ahead;
            default:   addr_next = addr_reg;
        endcase
    end

    always_comb begin
        case (cmd.hint_op)
            HINT_HOLD:  hint_next = hint_reg;
            HINT_SET:   hint_next = addr_reg;
            HINT_LOWER: hint_next = (addr_reg < hint_reg) ? addr_reg : hint_reg;
            default:    hint_next = hint_reg;
        endcase
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.out_load) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            hint_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            addr_reg    <= addr_next;
            hint_reg    <= hint_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            op_reg   <= s_tdata[1:0];
            page_reg <= s_tdata[17:2];
        end
        if (cmd.res_load) begin
            case (cmd.res_kind)
                RES_GRANT: begin
                    res_page_reg   <= grant_w[15:0];
                    res_status_reg <= 1'b0;
                end
                RES_FAIL: begin
                    res_page_reg   <= 16'd0;
                    res_status_reg <= 1'b1;
                end
                default: begin
                    res_page_reg   <= 16'd0;
                    res_status_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.out_load) begin
            out_page_reg   <= res_page_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat.op         = op_reg;
    assign stat.page_ok    = ({16'b0, page_reg} < NUM_PAGES_W);
    assign stat.addr_last  = addr_last;
    assign stat.free_found = |free_bits;
    assign stat.out_free   = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'b0, out_status_reg, out_page_reg};

endmodule

`default_nettype wire

@@ sv/bpa_ctrl.sv @@
// Controller state machine of the page allocator.
`default_nettype none

module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire ctrl_stat_t stat,
    output ctrl_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   is_alloc;
    logic   is_modify;

    assign is_alloc  = (stat.op == OP_ALLOC);
    assign is_modify = ((stat.op == OP_MARK) || (stat.op == OP_RELEASE)) && stat.page_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.addr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (is_alloc || is_modify) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_READ: begin
                state_next = is_alloc ? ST_ALLOC : ST_MODIFY;
            end
            ST_ALLOC: begin
                if (stat.free_found || stat.addr_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_MODIFY: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.req_load = 1'b0;
        cmd.addr_op  = ADDR_HOLD;
        cmd.rd_ahead = 1'b0;
        cmd.ram_we   = 1'b0;
        cmd.wr_kind  = WR_ZERO;
        cmd.hint_op  = HINT_HOLD;
        cmd.res_load = 1'b0;
        cmd.res_kind = RES_DONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.ram_we  = 1'b1;
                cmd.wr_kind = WR_ZERO;
                cmd.addr_op = stat.addr_last ? ADDR_ZERO : ADDR_INC;
            end
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.req_load = s_tvalid;
            end
            ST_DECODE: begin
                if (is_alloc) begin
                    cmd.addr_op = ADDR_HINT;
                end else if (is_modify) begin
                    cmd.addr_op = ADDR_PAGE;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_DONE;
                end
            end
            ST_READ: begin
                cmd.rd_ahead = 1'b0;
            end
            ST_ALLOC: begin
                cmd.rd_ahead = 1'b1;
                if (stat.free_found) begin
                    cmd.ram_we   = 1'b1;
                    cmd.wr_kind  = WR_GRANT;
                    cmd.hint_op  = HINT_SET;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_GRANT;
                end else if (stat.addr_last) begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_FAIL;
                end else begin
                    cmd.addr_op = ADDR_INC;
                end
            end
            ST_MODIFY: begin
                cmd.ram_we   = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_DONE;
                if (stat.op == OP_MARK) begin
                    cmd.wr_kind = WR_SET;
                end else begin
                    cmd.wr_kind = WR_CLEAR;
                    cmd.hint_op = HINT_LOWER;
                end
            end
            ST_RESP: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/bitmap_page_allocator.sv @@
// Top level of the bitmap page allocator: controller and datapath joined.
//
//  Channel | Direction | tdata fields, lowest bit up
//  s_      | in        | operation[1:0], page_number[17:2], zero pad to 24 bits
//  m_      | out       | granted_page[15:0], status[16], zero pad to 24 bits
//
// In-range mark and release pass the decode, read, modify and response states; other
// non-allocate requests go from decode to response. Allocate scans up from the hint.
// After reset a clearing pass writes zero to all (NUM_PAGES+7)/8 bitmap bytes
// while s_tready stays low.
// A new request is taken while an earlier result still waits on m_tready;
// the next result then stalls until that one is accepted.
`default_nettype none

module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = 65536
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // operation, page_number
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata    // granted_page, status
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    bpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bpa_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ sv/bpa_checker.sv @@
// Port-level assertion checker for the bitmap page allocator, with its bind.
`default_nettype none

`include "bitmap_page_allocator_defines.svh"

module bpa_checker
    import bpa_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [IN_TDATA_W-1:0]  s_tdata,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    logic in_taken;

    assign in_taken = s_tvalid && s_tready && (s_tdata[1:0] == s_tdata[1:0]);

    `BPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BPA_ASSERT_SAME(a_fail_zero, m_tvalid && m_tdata[16], m_tdata[15:0] == 16'd0)
    `BPA_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[23:17] == 7'd0)
    `BPA_ASSERT_NEXT(a_one_at_a_time, in_taken, !s_tready)

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

`default_nettype wire
